// ===== design/signed_int_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the checker files of the decimal text block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define S2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define S2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/s2d_pkg.sv =====
// Package: widths, ASCII codes, pipeline word types and the shift-add-3 step.
`timescale 1ns / 1ps

package s2d_pkg;

  localparam int MAG_W           = 32;
  localparam int NUM_DIGITS      = 10;
  localparam int DIG_IDX_W       = $clog2(NUM_DIGITS);
  localparam int CHAR_W          = 6;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_DD_STAGES   = MAG_W / STEPS_PER_STAGE;
  localparam int DD_W            = NUM_DIGITS * 4 + MAG_W;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

  // Double-dabble working word: BCD digits above the binary still to shift in
  typedef struct packed {
    digits_t          bcd;
    logic [MAG_W-1:0] bin;
  } dd_core_t;

  // Item as it travels down the pipeline
  typedef struct packed {
    logic     neg;
    dd_core_t core;
  } dd_word_t;

  // One conversion step: add 3 to every digit of 5 or more, then shift left
  function automatic dd_core_t dabble_step(input dd_core_t w);
    dd_core_t        t;
    logic [DD_W-1:0] f;
    t = w;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (t.bcd[k] >= 4'd5) begin
        t.bcd[k] = t.bcd[k] + 4'd3;
      end
    end
    f = t;
    return dd_core_t'({f[DD_W-2:0], 1'b0});
  endfunction

endpackage

// ===== design/s2d_front.sv =====
// Entry stage: takes the item, forms sign and 32-bit magnitude.
`timescale 1ns / 1ps

module s2d_front
  import s2d_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [MAG_W-1:0] in_value,
  output logic                    dn_valid,
  output dd_word_t                dn_word,
  input  logic                    dn_ready
);

  logic     valid_r;
  logic     valid_nxt;
  dd_word_t word_r;
  dd_word_t word_nxt;
  logic     neg;

  // Stage is blocked while it holds an item the next stage cannot take
  assign busy = valid_r && !dn_ready;

  // Two's-complement magnitude, exact for the most negative value
  always_comb begin
    neg               = in_value[MAG_W-1];
    word_nxt.neg      = neg;
    word_nxt.core.bcd = '0;
    word_nxt.core.bin = neg ? (~in_value + 1'b1) : in_value;
    valid_nxt         = busy ? valid_r : start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== design/s2d_dabble.sv =====
// Conversion stage: eight shift-add-3 steps of binary to BCD per register.
`timescale 1ns / 1ps

module s2d_dabble
  import s2d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  input  dd_word_t up_word,
  output logic     up_ready,
  output logic     dn_valid,
  output dd_word_t dn_word,
  input  logic     dn_ready
);

  logic     valid_r;
  logic     valid_nxt;
  dd_word_t word_r;
  dd_word_t word_nxt;
  dd_core_t acc;

  assign up_ready = !valid_r || dn_ready;

  // Chain of steps on the incoming word
  always_comb begin
    acc = up_word.core;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      acc = dabble_step(acc);
    end
    word_nxt.neg  = up_word.neg;
    word_nxt.core = acc;
    valid_nxt     = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== design/s2d_emit.sv =====
// Output serializer: sign, then significant digits one per cycle.
`timescale 1ns / 1ps

module s2d_emit
  import s2d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  dd_word_t          up_word,
  output logic              up_ready,
  output logic              out_strobe,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  logic                 active_r;
  logic                 active_nxt;
  logic                 sign_r;
  logic                 sign_nxt;
  logic [DIG_IDX_W-1:0] idx_r;
  logic [DIG_IDX_W-1:0] idx_nxt;
  digits_t              digits_r;
  logic [DIG_IDX_W-1:0] lead;
  logic                 load;
  logic                 at_last;

  // Position of the most significant nonzero digit; zero gives position 0
  always_comb begin
    lead = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (up_word.core.bcd[k] != 4'd0) begin
        lead = DIG_IDX_W'(k);
      end
    end
  end

  assign at_last  = !sign_r && (idx_r == '0);
  assign up_ready = !active_r || at_last;
  assign load     = up_valid && up_ready;

  // Walk: sign first if any, then digits downward to position 0
  always_comb begin
    active_nxt = active_r;
    sign_nxt   = sign_r;
    idx_nxt    = idx_r;
    if (load) begin
      active_nxt = 1'b1;
      sign_nxt   = up_word.neg;
      idx_nxt    = lead;
    end else if (active_r) begin
      if (sign_r) begin
        sign_nxt = 1'b0;
      end else if (idx_r == '0) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      sign_r   <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      sign_r   <= sign_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= up_word.core.bcd;
    end
  end

  assign out_strobe    = active_r;
  assign out_character = sign_r ? CHAR_MINUS : (CHAR_ZERO + {2'b00, digits_r[idx_r]});
  assign out_last      = at_last;

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per cycle.
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+-------------------------
//   input    | in_value[31:0]                          | start high, busy low
//   result   | out_character[5:0], out_last            | out_strobe, no back-pressure
//
// Pipeline: entry stage, four binary-to-BCD stages of eight steps each, serializer.
// An item passes the entry register and the four conversion registers into the
// serializer, which then gives its sign, if any, and its significant digits, and
// can take the next item on the last character of the current one. Items overlap in the
// pipeline behind it. Reset (synchronous, rst_n low) empties every stage. busy
// rises when the serializer holds the pipeline back and the entry stage is full.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii
  import s2d_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [MAG_W-1:0]  in_value,
  output logic                     out_strobe,
  output logic [CHAR_W-1:0]        out_character,
  output logic                     out_last
);

  logic     st_valid [NUM_DD_STAGES+1];
  dd_word_t st_word  [NUM_DD_STAGES+1];
  logic     st_ready [NUM_DD_STAGES+1];

  s2d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .dn_valid (st_valid[0]),
    .dn_word  (st_word[0]),
    .dn_ready (st_ready[0])
  );

  // Conversion stages in a row
  for (genvar g = 0; g < NUM_DD_STAGES; g++) begin : g_dd
    s2d_dabble u_dabble (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[g]),
      .up_word  (st_word[g]),
      .up_ready (st_ready[g]),
      .dn_valid (st_valid[g+1]),
      .dn_word  (st_word[g+1]),
      .dn_ready (st_ready[g+1])
    );
  end

  s2d_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (st_valid[NUM_DD_STAGES]),
    .up_word       (st_word[NUM_DD_STAGES]),
    .up_ready      (st_ready[NUM_DD_STAGES]),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

// ===== design/s2d_checker.sv =====
// Port-level checker for the decimal text block, with its bind.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_macros.svh"

module s2d_checker
  import s2d_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_strobe,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last
);

  logic is_minus;
  logic is_digit;

  assign is_minus = (out_character == CHAR_MINUS);
  assign is_digit = (out_character >= CHAR_ZERO) && (out_character <= CHAR_ZERO + 6'd9);

  // A run of text continues without gaps until its last character
  `S2D_ASSERT_NEXT(a_run_no_gap, out_strobe && !out_last, out_strobe, "gap inside a text run")
  // Only a minus sign or a digit ever leaves
  `S2D_ASSERT_NOW(a_char_legal, out_strobe, is_minus || is_digit, "illegal character code")
  // The sign never ends a run
  `S2D_ASSERT_NOW(a_minus_not_last, out_strobe && is_minus, !out_last, "minus marked last")
  // A digit always follows the sign
  `S2D_ASSERT_NEXT(a_digit_after_minus, out_strobe && is_minus, out_strobe && is_digit,
                   "no digit after minus")

endmodule

bind signed_int_to_decimal_ascii s2d_checker u_s2d_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_strobe    (out_strobe),
  .out_character (out_character),
  .out_last      (out_last)
);

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
// Testbench for the signed integer to decimal ASCII text block: directed, random, back-to-back and drain tests.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
  import s2d_pkg::*;

  // cycles with neither an item taken nor a character out before giving up
  localparam int STALL_LIMIT  = 200;
  // settle time after the last expected character, well past the pipeline depth
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [MAG_W-1:0] in_value;
  logic                    out_strobe;
  logic [CHAR_W-1:0]       out_character;
  logic                    out_last;

  text_char_t expected_text[$];
  text_char_t want_char;
  int         errors       = 0;
  int         stall_cycles = 0;
  bit         gap_en       = 1'b1;

  signed_int_to_decimal_ascii dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Expected text of one value: optional minus sign, then digits MSD first
  function automatic void predict_text(input logic [MAG_W-1:0] v);
    logic [MAG_W-1:0] mag;
    logic [3:0]       digit [NUM_DIGITS];
    int               nd;
    mag = v[MAG_W-1] ? ~v + 1'b1 : v;
    nd  = 0;
    do begin
      digit[nd] = 4'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    if (v[MAG_W-1]) begin
      expected_text.push_back('{code: CHAR_MINUS, last: 1'b0});
    end
    for (int i = nd - 1; i >= 0; i--) begin
      expected_text.push_back('{code: CHAR_ZERO + CHAR_W'(digit[i]), last: (i == 0)});
    end
  endfunction

  // Random value, weighted toward each digit count, powers of ten, small values and the limits
  function automatic logic signed [MAG_W-1:0] pick_test_value();
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      p;
    int               nd;
    logic [MAG_W-1:0] mag;
    case ($urandom_range(0, 4))
      0: begin
        return $urandom;
      end
      1: begin
        nd = $urandom_range(1, NUM_DIGITS);
        lo = 1;
        repeat (nd - 1) lo = lo * 10;
        hi = (nd == NUM_DIGITS) ? 32'h8000_0000 : lo * 10 - 1;
        mag = $urandom_range(hi, lo);
      end
      2: begin
        p = 1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        mag = p + $urandom_range(0, 2) - 1;
      end
      3: begin
        mag = $urandom_range(0, 20);
      end
      default: begin
        return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(0, 9)
                                 : 32'h8000_0000 + $urandom_range(0, 9);
      end
    endcase
    // 2^31 only exists as a negative value
    return ($urandom_range(1) || mag[MAG_W-1]) ? -mag : mag;
  endfunction

  // Present one item, idling at random cycle by cycle first, and hold it until taken
  task automatic send_value(input logic signed [MAG_W-1:0] v);
    @(negedge clk);
    while (gap_en && ($urandom_range(99) < 38)) begin
      start    <= 1'b0;
      in_value <= $urandom;
      @(negedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    predict_text(v);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    start    <= 1'b0;
    in_value <= $urandom;
  endtask

  task automatic wait_text_drained();
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  // Zero, single digits, digit-count boundaries, both limits, alternating bits
  task automatic test_directed_values();
    logic signed [MAG_W-1:0] corner [20] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, -101, 12345,
      32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
      1000000000, -1000000000, 999999999, -999999999,
      32'sh5555_5555, 32'shAAAA_AAAA
    };
    foreach (corner[i]) send_value(corner[i]);
  endtask

  task automatic test_random_values(input int n);
    repeat (n) send_value(pick_test_value());
  endtask

  // Items offered every cycle so the serializer holds the entry stage off
  task automatic test_back_to_back(input int n);
    gap_en = 1'b0;
    repeat (n) send_value(pick_test_value());
    gap_en = 1'b1;
  endtask

  // Short bursts, each followed by a full drain of the pipeline
  task automatic test_drain_between_bursts();
    repeat (8) begin
      repeat (5) send_value(pick_test_value());
      stop_sending();
      wait_text_drained();
    end
  endtask

  task automatic finish_run();
    stop_sending();
    wait_text_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  endtask

  // Compare each character against the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_text.size() == 0) begin
        $error("character: expected none, got %0d (last %0b)", out_character, out_last);
        errors++;
      end else begin
        want_char = expected_text.pop_front();
        if (out_character !== want_char.code) begin
          $error("character: expected %0d, got %0d", want_char.code, out_character);
          errors++;
        end
        if (out_last !== want_char.last) begin
          $error("last: expected %0b, got %0b", want_char.last, out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item taken and no character out
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_values();
    test_random_values(120);
    test_back_to_back(60);
    test_drain_between_bursts();
    test_random_values(110);
    finish_run();
  end

endmodule
